/* rtl/core/pvfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pvfp_pkg;

   // byte queue between the front and the back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // parser phases
   localparam logic [1:0] PH_TAG    = 2'd0;
   localparam logic [1:0] PH_VALUE  = 2'd1;
   localparam logic [1:0] PH_LENGTH = 2'd2;
   localparam logic [1:0] PH_SKIP   = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_LONG  = 2'd1;
   localparam logic [1:0] ST_BAD_WIRE  = 2'd2;
   localparam logic [1:0] ST_TRUNCATED = 2'd3;

   // wire types that are handled
   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_I64    = 3'd1;
   localparam logic [2:0] WT_LEN    = 3'd2;
   localparam logic [2:0] WT_I32    = 3'd5;

   localparam logic [63:0] SKIP_I64 = 64'd8;
   localparam logic [63:0] SKIP_I32 = 64'd4;

   // varint byte index of the tenth byte
   localparam logic [3:0] LAST_VARINT_IDX = 4'd9;
   localparam logic [3:0] MAX_FIELD_NUM   = 4'd9;

   typedef struct packed {
      logic       last;
      logic       cont;
      logic [6:0] payload;
   } pvfp_entry_type;

endpackage

`default_nettype wire

/* rtl/core/protobuf_varint_field_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// an accepted req byte goes through the byte queue and then the rsp register to its rsp beat
// throughput: one section byte per cycle while no pending rsp beat is held by
//    rsp_tready; the back updates the varint accumulator or the 64-bit skip count for each byte
// bytes that finish nothing and are not last give no rsp beat
// reset: synchronous, active high; empties the byte queue, returns the parser
//    to the tag phase and drops any pending rsp beat
module protobuf_varint_field_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel: one section byte per beat
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // last_byte
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [3:0] field_id, [67:4] field_value, rest zero
   output logic             rsp_tlast,   // section_done
   output logic [2:0]       rsp_tuser    // [0] field_valid, [2:1] status
);
   import pvfp_pkg::*;

   // front to back: head of the byte queue
   logic           head_valid;
   pvfp_entry_type head_entry;
   logic           head_pop;
   logic           draining;

   // front: accept, split each byte into continuation flag and payload, queue it
   pvfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop)
   );

   // back: tag / value / length varints, skip count, error draining, rsp register
   pvfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .draining   (draining)
   );

   // a field result always carries ok status and a field number from 1 to 9
   a_field_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tuser[2:1] == ST_OK) && (rsp_tdata[3:0] != 4'd0) &&
         (rsp_tdata[3:0] <= MAX_FIELD_NUM))
      else $error("field result with bad status or number");

   // truncation is only reported on the last byte of a section
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2:1] == ST_TRUNCATED) |-> rsp_tlast)
      else $error("truncation reported before section end");

   // draining starts together with an error beat that does not end the section
   a_drain_start: assert property (@(posedge clock) disable iff (reset)
      $rose(draining) |-> rsp_tvalid && (rsp_tuser[2:1] != ST_OK) && !rsp_tlast)
      else $error("drain without a pending error beat");

   // the last byte always brings the parser out of draining
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (draining && head_pop && head_entry.last) |=> !draining)
      else $error("draining kept past section end");

endmodule

`default_nettype wire

/* rtl/core/pvfp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module pvfp_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,
   input  wire logic                     req_tlast,
   output logic                          head_valid,
   output pvfp_pkg::pvfp_entry_type      head_entry,
   input  wire logic                     head_pop
);
   import pvfp_pkg::*;

   pvfp_entry_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   pvfp_entry_type     classified;
   logic               push;
   logic               pop;

   // split the byte into continuation flag and payload bits
   always_comb begin
      classified.last    = req_tlast;
      classified.cont    = req_tdata[7];
      classified.payload = req_tdata[6:0];
   end

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/pvfp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module pvfp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     head_valid,
   input  wire pvfp_pkg::pvfp_entry_type head_entry,
   output logic                          head_pop,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [71:0]                   rsp_tdata,
   output logic                          rsp_tlast,
   output logic [2:0]                    rsp_tuser,
   output logic                          draining
);
   import pvfp_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  idx_ff, idx_in;
   logic [3:0]  held_field_ff, held_field_in;
   logic        held_known_ff, held_known_in;
   logic [63:0] skip_ff, skip_in;
   logic        drain_ff, drain_in;

   logic        rsp_valid_ff;
   logic [3:0]  rsp_number_ff;
   logic [63:0] rsp_value_ff;
   logic        rsp_last_ff;
   logic        rsp_fvalid_ff;
   logic [1:0]  rsp_status_ff;

   logic        out_ok;
   logic        emit;
   logic        fvalid;
   logic [3:0]  fnum;
   logic [63:0] fval;
   logic [1:0]  status;
   logic [6:0]  shamt;
   logic [63:0] acc_or;
   logic [63:0] skip_dec;
   logic [3:0]  tag_num;
   logic        tag_known;
   logic [2:0]  tag_wt;

   assign out_ok   = !rsp_valid_ff || rsp_tready;
   assign head_pop = head_valid && out_ok;
   assign draining = drain_ff;

   // shift is 7 times the byte index
   assign shamt    = {idx_ff, 3'b000} - {3'b000, idx_ff};
   assign acc_or   = acc_ff | ({57'd0, head_entry.payload} << shamt);
   assign skip_dec = skip_ff - {63'd0, (skip_ff != '0)};

   assign tag_num   = acc_or[6:3];
   assign tag_wt    = acc_or[2:0];
   assign tag_known = (acc_or[63:7] == '0) && (tag_num != '0) && (tag_num <= MAX_FIELD_NUM);

   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      idx_in        = idx_ff;
      held_field_in = held_field_ff;
      held_known_in = held_known_ff;
      skip_in       = skip_ff;
      drain_in      = drain_ff;
      fvalid        = 1'b0;
      fnum          = '0;
      fval          = '0;
      status        = ST_OK;

      if (!drain_ff) begin
         if (phase_ff == PH_SKIP) begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               phase_in = PH_TAG;
            end
         end else if (head_entry.cont) begin
            acc_in = acc_or;
            if (idx_ff >= LAST_VARINT_IDX) begin
               status = ST_TOO_LONG;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else begin
            acc_in = '0;
            idx_in = '0;
            unique case (phase_ff)
               PH_TAG: begin
                  held_known_in = tag_known;
                  held_field_in = tag_known ? tag_num : '0;
                  unique case (tag_wt)
                     WT_VARINT: phase_in = PH_VALUE;
                     WT_I64: begin
                        phase_in = PH_SKIP;
                        skip_in  = SKIP_I64;
                     end
                     WT_I32: begin
                        phase_in = PH_SKIP;
                        skip_in  = SKIP_I32;
                     end
                     WT_LEN:  phase_in = PH_LENGTH;
                     default: status = ST_BAD_WIRE;
                  endcase
               end
               PH_VALUE: begin
                  if (held_known_ff) begin
                     fvalid = 1'b1;
                     fnum   = held_field_ff;
                     fval   = acc_or;
                  end
                  phase_in = PH_TAG;
               end
               default: begin
                  if (acc_or == '0) begin
                     phase_in = PH_TAG;
                  end else begin
                     phase_in = PH_SKIP;
                     skip_in  = acc_or;
                  end
               end
            endcase
         end
         if (status == ST_OK && head_entry.last && (phase_in != PH_TAG || idx_in != '0)) begin
            status = ST_TRUNCATED;
         end
         if (status != ST_OK && !head_entry.last) begin
            drain_in = 1'b1;
         end
      end

      // end of section: back to the reset state
      if (head_entry.last) begin
         phase_in      = PH_TAG;
         acc_in        = '0;
         idx_in        = '0;
         held_field_in = '0;
         held_known_in = 1'b0;
         skip_in       = '0;
         drain_in      = 1'b0;
      end
   end

   assign emit = fvalid || (status != ST_OK) || head_entry.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TAG;
         acc_ff        <= '0;
         idx_ff        <= '0;
         held_field_ff <= '0;
         held_known_ff <= 1'b0;
         skip_ff       <= '0;
         drain_ff      <= 1'b0;
      end else if (head_pop) begin
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         idx_ff        <= idx_in;
         held_field_ff <= held_field_in;
         held_known_ff <= held_known_in;
         skip_ff       <= skip_in;
         drain_ff      <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (head_pop && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop && emit) begin
         rsp_number_ff <= fnum;
         rsp_value_ff  <= fval;
         rsp_last_ff   <= head_entry.last;
         rsp_fvalid_ff <= fvalid;
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_value_ff, rsp_number_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_fvalid_ff};

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import pvfp_pkg::*;

   localparam int CYCLE_LIMIT  = 1500000;
   localparam int RANDOM_BYTES = 1800;
   localparam int DRAIN_CYCLES = 20;

   // wire types the parser rejects
   localparam logic [2:0] WT_SGROUP = 3'd3;
   localparam logic [2:0] WT_EGROUP = 3'd4;
   localparam logic [2:0] WT_RSVD6  = 3'd6;
   localparam logic [2:0] WT_RSVD7  = 3'd7;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } section_byte_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  number;
      logic [63:0] value;
      logic        done;
      logic [1:0]  status;
   } parsed_field_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;

   protobuf_varint_field_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   section_byte_type section_buf_q[$];
   section_byte_type byte_stream[$];
   parsed_field_type expected_fields[$];

   int  bytes_total;
   int  bytes_sent;
   int  mismatches;
   int  cycle_count;
   bit  req_taken;
   bit  rsp_taken;
   int  req_gap;
   int  rsp_hold;
   bit  req_steady;
   bit  rsp_steady;

   // decoder state of the predictor
   logic [1:0]  dec_phase;
   logic [63:0] dec_acc;
   logic [6:0]  dec_shift;
   logic [3:0]  dec_field;
   logic        dec_known;
   logic [63:0] dec_skip;
   logic        dec_drain;

   task automatic clear_decoder();
      dec_phase = PH_TAG;
      dec_acc   = '0;
      dec_shift = '0;
      dec_field = '0;
      dec_known = 1'b0;
      dec_skip  = '0;
      dec_drain = 1'b0;
   endtask

   // advance the decoder by one section byte and queue the beat it causes
   task automatic decode_byte(input logic [7:0] b, input logic last);
      parsed_field_type r;
      logic [63:0]      v;
      logic [60:0]      num;
      logic             done;
      r    = '0;
      v    = '0;
      done = 1'b0;
      if (!dec_drain) begin
         if (dec_phase == PH_SKIP) begin
            if (dec_skip != 0) dec_skip--;
            if (dec_skip == 0) dec_phase = PH_TAG;
         end else begin
            dec_acc |= {57'd0, b[6:0]} << dec_shift[5:0];
            if (b[7]) begin
               if (dec_shift >= 7'd63) r.status = ST_TOO_LONG;
               else dec_shift += 7'd7;
            end else begin
               done      = 1'b1;
               v         = dec_acc;
               dec_acc   = '0;
               dec_shift = '0;
            end
            if (done) begin
               case (dec_phase)
                  PH_TAG: begin
                     num       = v[63:3];
                     dec_known = (num >= 61'd1) && (num <= 61'(MAX_FIELD_NUM));
                     dec_field = dec_known ? num[3:0] : 4'd0;
                     case (v[2:0])
                        WT_VARINT: dec_phase = PH_VALUE;
                        WT_I64: begin
                           dec_phase = PH_SKIP;
                           dec_skip  = SKIP_I64;
                        end
                        WT_I32: begin
                           dec_phase = PH_SKIP;
                           dec_skip  = SKIP_I32;
                        end
                        WT_LEN: dec_phase = PH_LENGTH;
                        default: r.status = ST_BAD_WIRE;
                     endcase
                  end
                  PH_VALUE: begin
                     if (dec_known) begin
                        r.valid  = 1'b1;
                        r.number = dec_field;
                        r.value  = v;
                     end
                     dec_phase = PH_TAG;
                  end
                  default: begin
                     // length byte: zero length closes the field right here
                     if (v == 0) begin
                        dec_phase = PH_TAG;
                     end else begin
                        dec_phase = PH_SKIP;
                        dec_skip  = v;
                     end
                  end
               endcase
            end
         end
         if (r.status == ST_OK && last && (dec_phase != PH_TAG || dec_shift != 0))
            r.status = ST_TRUNCATED;
         if (r.status != ST_OK && !last) dec_drain = 1'b1;
      end
      r.done = last;
      if (r.valid || r.status != ST_OK || last) expected_fields = {expected_fields, r};
      if (last) clear_decoder();
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // ---------------- stimulus construction ----------------

   function automatic int pick_gap(input bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      int          w;
      w = $urandom_range(0, 64);
      v = {$urandom, $urandom};
      if (w < 64) v &= (64'd1 << w) - 64'd1;
      return v;
   endfunction

   // mostly minimal encodings, sometimes padded out with zero groups
   function automatic int pad_len();
      if ($urandom_range(0, 99) < 85) return 1;
      return $urandom_range(2, 10);
   endfunction

   function automatic logic [60:0] pick_field_num();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 61'($urandom_range(1, 9));
      if (r < 85) return 61'd0;
      if (r < 95) return 61'($urandom_range(10, 31));
      return 61'(rand64() >> 3);
   endfunction

   function automatic logic [2:0] pick_bad_wire();
      case ($urandom_range(0, 3))
         0:       return WT_SGROUP;
         1:       return WT_EGROUP;
         2:       return WT_RSVD6;
         default: return WT_RSVD7;
      endcase
   endfunction

   task automatic put_byte(input logic [7:0] b);
      section_byte_type sb;
      sb.data = b;
      sb.last = 1'b0;
      section_buf_q = {section_buf_q, sb};
   endtask

   task automatic put_random(input int n);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic put_varint(input logic [63:0] v, input int min_len);
      logic [7:0] b;
      int         n;
      logic       more;
      n = 0;
      do begin
         b = {1'b0, v[6:0]};
         v = v >> 7;
         n++;
         more = (v != 0) || (n < min_len);
         // tenth group: only bit 0 lands in the value, the rest must be dropped
         if (n == 10 && $urandom_range(0, 1)) b[6:1] = 6'($urandom_range(0, 63));
         b[7] = more;
         put_byte(b);
      end while (more);
   endtask

   task automatic put_tag(input logic [60:0] num, input logic [2:0] wt);
      put_varint({num, wt}, pad_len());
   endtask

   // ten groups that all keep the continuation bit
   task automatic put_too_long();
      repeat (10) put_byte(8'h80 | 8'($urandom_range(0, 127)));
   endtask

   task automatic put_field();
      int          r;
      int          len;
      logic [60:0] num;
      r   = $urandom_range(0, 99);
      num = pick_field_num();
      if (r < 48) begin
         put_tag(num, WT_VARINT);
         put_varint(rand64(), pad_len());
      end else if (r < 60) begin
         put_tag(num, WT_I64);
         put_random(8);
      end else if (r < 72) begin
         put_tag(num, WT_I32);
         put_random(4);
      end else if (r < 92) begin
         len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 8) : $urandom_range(9, 40);
         put_tag(num, WT_LEN);
         put_varint(64'(len), pad_len());
         put_random(len);
      end else if (r < 96) begin
         put_tag(num, pick_bad_wire());
         put_random($urandom_range(0, 3));
      end else begin
         put_tag(num, WT_VARINT);
         put_too_long();
      end
   endtask

   // cut or garble if asked, flag the final byte, move it to the send queue
   task automatic end_section(input bit cut, input bit garble);
      section_byte_type sb;
      int               keep;
      if (cut && section_buf_q.size() > 1) begin
         keep = $urandom_range(1, section_buf_q.size() - 1);
         section_buf_q = section_buf_q[0:keep-1];
      end
      if (garble)
         section_buf_q[$urandom_range(0, section_buf_q.size() - 1)].data =
            8'($urandom_range(0, 255));
      foreach (section_buf_q[i]) begin
         sb      = section_buf_q[i];
         sb.last = (i == section_buf_q.size() - 1);
         byte_stream = {byte_stream, sb};
      end
      section_buf_q.delete();
   endtask

   // ---------------- request driver ----------------

   always @(negedge clock) begin : drive_req
      section_byte_type nxt;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (byte_stream.size() > 0) begin
            nxt = byte_stream.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.data;
            req_tlast  <= nxt.last;
            if ($urandom_range(0, 199) == 0) req_steady = !req_steady;
            req_gap = pick_gap(req_steady);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------- result receiver ----------------

   always @(negedge clock) begin : drive_rsp
      if (!reset) begin
         if (rsp_taken || $urandom_range(0, 15) == 0) begin
            if ($urandom_range(0, 299) == 0) rsp_steady = !rsp_steady;
            if (rsp_hold == 0) rsp_hold = pick_gap(rsp_steady);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin : watch
      parsed_field_type want;
      req_taken = !reset && req_tvalid && req_tready;
      rsp_taken = !reset && rsp_tvalid && rsp_tready;
      if (rsp_taken) begin
         if (expected_fields.size() == 0) begin
            $error("result beat with nothing expected: tdata 0x%0h tuser 0x%0h tlast %0b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            mismatches++;
         end else begin
            want = expected_fields.pop_front();
            check_field("field_valid", 64'(want.valid), 64'(rsp_tuser[0]));
            check_field("field_id", 64'(want.number), 64'(rsp_tdata[3:0]));
            check_field("field_value", want.value, rsp_tdata[67:4]);
            check_field("tdata padding", 64'd0, 64'(rsp_tdata[71:68]));
            check_field("section_done", 64'(want.done), 64'(rsp_tlast));
            check_field("status", 64'(want.status), 64'(rsp_tuser[2:1]));
         end
      end
      if (req_taken) begin
         bytes_sent++;
         decode_byte(req_tdata, req_tlast);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[protobuf_varint_field_parser] ERROR");
         $finish;
      end
   end

   // ---------------- test sequence ----------------

   initial begin : run
      int r;
      clear_decoder();

      // field 1 with value zero, then field 9 with a full 64-bit value
      put_tag(61'd1, WT_VARINT);
      put_varint(64'd0, 1);
      put_tag(61'd9, WT_VARINT);
      put_varint('1, 1);
      end_section(1'b0, 1'b0);
      // bad wire type on the very byte that ends the section
      put_tag(61'd1, WT_SGROUP);
      end_section(1'b0, 1'b0);
      // zero-length delimited field closes at its length byte
      put_tag(61'd2, WT_LEN);
      put_varint(64'd0, 1);
      end_section(1'b0, 1'b0);
      // section ends while fixed 64-bit bytes are still owed
      put_tag(61'd9, WT_I64);
      put_random(2);
      end_section(1'b0, 1'b0);
      // over-long tag varint, then a dropped byte carrying the end flag
      put_too_long();
      put_random(1);
      end_section(1'b0, 1'b0);

      while (byte_stream.size() < RANDOM_BYTES) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            put_random($urandom_range(1, 12));
            end_section(1'b0, 1'b0);
         end else begin
            repeat ($urandom_range(1, 5)) put_field();
            end_section(r < 18, r >= 18 && r < 24);
         end
      end
      bytes_total = byte_stream.size();

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      while (bytes_sent < bytes_total || expected_fields.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0) begin
         $display("[protobuf_varint_field_parser] OK");
      end else begin
         $display("[protobuf_varint_field_parser] ERROR");
      end
      $finish;
   end

endmodule
